// ===== rtl/lsct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_pkg: shared constants of the line / segment cross test
// Coordinate width default and the distance register's width and reset value.
// ----------------------------------------------------------------------------
package lsct_pkg;

  // Default width of one coordinate, two's complement.
  localparam int LSCT_COORD_WIDTH = 16;

  // Distance register and its square.
  localparam int LSCT_HD_WIDTH    = 12;
  localparam int LSCT_HD_SQ_WIDTH = 2 * LSCT_HD_WIDTH;
  localparam int LSCT_HD_RESET    = 4;
  localparam int LSCT_HD_SQ_RESET = LSCT_HD_RESET * LSCT_HD_RESET;

endpackage

// ===== rtl/lsct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_if: valid / ready channels of the line / segment cross test
// One channel carries the query word, the other carries the result word.
// ----------------------------------------------------------------------------
interface lsct_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] line_ax;
  logic signed [COORD_WIDTH-1:0] line_ay;
  logic signed [COORD_WIDTH-1:0] line_bx;
  logic signed [COORD_WIDTH-1:0] line_by;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;

  modport source (
    output valid, line_ax, line_ay, line_bx, line_by,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );
  modport sink (
    input  valid, line_ax, line_ay, line_bx, line_by,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

interface lsct_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic degenerate_line;

  modport source (
    output valid, hit, degenerate_line,
    input  ready
  );
  modport sink (
    input  valid, hit, degenerate_line,
    output ready
  );
endinterface

// ===== rtl/lsct_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_cross: cross products and squared line length
// Three stages: coordinate differences, products, then the two cross
// products and the squared length of the line direction.
// ----------------------------------------------------------------------------
module lsct_cross #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   line_ax,
  input  logic signed [COORD_WIDTH-1:0]   line_ay,
  input  logic signed [COORD_WIDTH-1:0]   line_bx,
  input  logic signed [COORD_WIDTH-1:0]   line_by,
  input  logic signed [COORD_WIDTH-1:0]   seg_start_x,
  input  logic signed [COORD_WIDTH-1:0]   seg_start_y,
  input  logic signed [COORD_WIDTH-1:0]   seg_end_x,
  input  logic signed [COORD_WIDTH-1:0]   seg_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [2*COORD_WIDTH+1:0] cross_s,
  output logic signed [2*COORD_WIDTH+1:0] cross_e,
  output logic        [2*COORD_WIDTH:0]   len_sq,
  output logic                            degenerate
);
  import lsct_pkg::*;

  localparam int DW = COORD_WIDTH + 1;       // coordinate difference
  localparam int PW = 2 * COORD_WIDTH + 2;   // product and cross product
  localparam int LW = 2 * COORD_WIDTH + 1;   // squared length

  logic [2:0] vld_r;
  logic [2:0] adv;

  // Stage 1
  logic signed [DW-1:0] dx_r, dy_r, sax_r, say_r, eax_r, eay_r;
  logic                 deg1_r;
  // Stage 2
  logic signed [PW-1:0] p_sy_r, p_sx_r, p_ey_r, p_ex_r, dxx_r, dyy_r;
  logic                 deg2_r;
  // Stage 3
  logic signed [PW-1:0] cs_r, ce_r;
  logic [LW-1:0]        len_r;
  logic                 deg3_r;

  // A stage takes a new word when it is empty or its word moves on.
  assign adv[2] = !vld_r[2] || out_ready;
  assign adv[1] = !vld_r[1] || adv[2];
  assign adv[0] = !vld_r[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r   <= DW'(line_bx) - DW'(line_ax);
      dy_r   <= DW'(line_by) - DW'(line_ay);
      sax_r  <= DW'(seg_start_x) - DW'(line_ax);
      say_r  <= DW'(seg_start_y) - DW'(line_ay);
      eax_r  <= DW'(seg_end_x) - DW'(line_ax);
      eay_r  <= DW'(seg_end_y) - DW'(line_ay);
      deg1_r <= (line_ax == line_bx) && (line_ay == line_by);
    end
    if (adv[1]) begin
      p_sy_r <= PW'(dx_r) * PW'(say_r);
      p_sx_r <= PW'(dy_r) * PW'(sax_r);
      p_ey_r <= PW'(dx_r) * PW'(eay_r);
      p_ex_r <= PW'(dy_r) * PW'(eax_r);
      dxx_r  <= PW'(dx_r) * PW'(dx_r);
      dyy_r  <= PW'(dy_r) * PW'(dy_r);
      deg2_r <= deg1_r;
    end
    if (adv[2]) begin
      cs_r   <= p_sy_r - p_sx_r;
      ce_r   <= p_ey_r - p_ex_r;
      len_r  <= dxx_r[LW-1:0] + dyy_r[LW-1:0];
      deg3_r <= deg2_r;
    end
  end

  assign out_valid  = vld_r[2];
  assign cross_s    = cs_r;
  assign cross_e    = ce_r;
  assign len_sq     = len_r;
  assign degenerate = deg3_r;

endmodule

// ===== rtl/lsct_square.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_square: squared cross products and the distance limit
// Three stages: magnitudes and side test, split partial products, and the
// sums that rebuild the full squares and the limit.
// ----------------------------------------------------------------------------
module lsct_square #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [2*COORD_WIDTH+1:0]        cross_s,
  input  logic signed [2*COORD_WIDTH+1:0]        cross_e,
  input  logic        [2*COORD_WIDTH:0]          len_sq,
  input  logic                                   degenerate,
  input  logic [lsct_pkg::LSCT_HD_SQ_WIDTH-1:0]  hd_sq,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [4*COORD_WIDTH+1:0]               sq_s,
  output logic [4*COORD_WIDTH+1:0]               sq_e,
  output logic [2*COORD_WIDTH+lsct_pkg::LSCT_HD_SQ_WIDTH:0] limit,
  output logic                                   crossing,
  output logic                                   degenerate_out
);
  import lsct_pkg::*;

  localparam int PW   = 2 * COORD_WIDTH + 2;   // signed cross product
  localparam int MW   = 2 * COORD_WIDTH + 1;   // its magnitude
  localparam int LW   = 2 * COORD_WIDTH + 1;   // squared length
  localparam int H    = COORD_WIDTH + 1;       // low split width
  localparam int MHW  = MW - H;                // high part of magnitude
  localparam int LHW  = LW - H;                // high part of length
  localparam int SQW  = 2 * MW;
  localparam int LIMW = LW + LSCT_HD_SQ_WIDTH;

  logic [2:0] vld_r;
  logic [2:0] adv;

  // Stage 4
  logic [MW-1:0] ms_r, me_r;
  logic [LW-1:0] len4_r;
  logic          cross4_r, deg4_r;
  // Stage 5
  logic [2*H-1:0]                  s_ll_r, e_ll_r;
  logic [H+MHW-1:0]                s_lh_r, e_lh_r;
  logic [2*MHW-1:0]                s_hh_r, e_hh_r;
  logic [H+LSCT_HD_SQ_WIDTH-1:0]   lim_l_r;
  logic [LHW+LSCT_HD_SQ_WIDTH-1:0] lim_h_r;
  logic                            cross5_r, deg5_r;
  // Stage 6
  logic [SQW-1:0]  sqs_r, sqe_r;
  logic [LIMW-1:0] lim_r;
  logic            cross6_r, deg6_r;

  logic [PW-1:0] neg_s, neg_e;
  logic          pos_s, pos_e;

  assign neg_s = -cross_s;
  assign neg_e = -cross_e;
  assign pos_s = !cross_s[PW-1] && (cross_s != '0);
  assign pos_e = !cross_e[PW-1] && (cross_e != '0);

  assign adv[2] = !vld_r[2] || out_ready;
  assign adv[1] = !vld_r[1] || adv[2];
  assign adv[0] = !vld_r[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ms_r     <= cross_s[PW-1] ? neg_s[MW-1:0] : cross_s[MW-1:0];
      me_r     <= cross_e[PW-1] ? neg_e[MW-1:0] : cross_e[MW-1:0];
      len4_r   <= len_sq;
      // Strictly opposite sides: one product positive, the other negative.
      cross4_r <= (pos_s && cross_e[PW-1]) || (cross_s[PW-1] && pos_e);
      deg4_r   <= degenerate;
    end
    if (adv[1]) begin
      s_ll_r   <= (2*H)'(ms_r[H-1:0]) * (2*H)'(ms_r[H-1:0]);
      s_lh_r   <= (H+MHW)'(ms_r[H-1:0]) * (H+MHW)'(ms_r[MW-1:H]);
      s_hh_r   <= (2*MHW)'(ms_r[MW-1:H]) * (2*MHW)'(ms_r[MW-1:H]);
      e_ll_r   <= (2*H)'(me_r[H-1:0]) * (2*H)'(me_r[H-1:0]);
      e_lh_r   <= (H+MHW)'(me_r[H-1:0]) * (H+MHW)'(me_r[MW-1:H]);
      e_hh_r   <= (2*MHW)'(me_r[MW-1:H]) * (2*MHW)'(me_r[MW-1:H]);
      lim_l_r  <= (H+LSCT_HD_SQ_WIDTH)'(len4_r[H-1:0]) *
                  (H+LSCT_HD_SQ_WIDTH)'(hd_sq);
      lim_h_r  <= (LHW+LSCT_HD_SQ_WIDTH)'(len4_r[LW-1:H]) *
                  (LHW+LSCT_HD_SQ_WIDTH)'(hd_sq);
      cross5_r <= cross4_r;
      deg5_r   <= deg4_r;
    end
    if (adv[2]) begin
      // The low and high squares do not overlap, so they just concatenate.
      sqs_r    <= {s_hh_r, s_ll_r} + SQW'({s_lh_r, {(H+1){1'b0}}});
      sqe_r    <= {e_hh_r, e_ll_r} + SQW'({e_lh_r, {(H+1){1'b0}}});
      lim_r    <= {lim_h_r, {H{1'b0}}} + LIMW'(lim_l_r);
      cross6_r <= cross5_r;
      deg6_r   <= deg5_r;
    end
  end

  assign out_valid      = vld_r[2];
  assign sq_s           = sqs_r;
  assign sq_e           = sqe_r;
  assign limit          = lim_r;
  assign crossing       = cross6_r;
  assign degenerate_out = deg6_r;

endmodule

// ===== rtl/line_segment_cross_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_cross_test_unit: line / segment touch and cross test
// Reports whether a segment crosses, or comes near, an infinite line.
// ----------------------------------------------------------------------------
// Usage:
// The query channel (in_word) carries one word per test: two points A and B
// on the line and the segment endpoints S and E. The result channel
// (out_word) returns one word per query, in order: hit and degenerate_line.
// hit is set when S and E lie strictly on opposite sides of the line, or
// when either endpoint lies closer to the line than hit_distance. The
// distance test is exact: cross(P)^2 < hit_distance^2 * |B - A|^2.
// When A equals B, degenerate_line is set and hit is cleared.
// The distance register is written through cfg_wr_en / cfg_wr_data. The user
// must write it only while no query is in flight; the block does not enforce
// this. It resets to 4. The seven register stages each hold one word and a
// stage is refilled as soon as its word moves on. The block accepts one query
// every cycle while the result channel does not stall.
// A stall on the result channel fills the stages one by one; only when all
// seven hold a word does in_word.ready drop. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties every stage and reloads the
// distance register.
// ----------------------------------------------------------------------------
module line_segment_cross_test_unit #(
  parameter int COORD_WIDTH = lsct_pkg::LSCT_COORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lsct_pkg::LSCT_HD_WIDTH-1:0] cfg_wr_data,
  lsct_in_if.sink                            in_word,
  lsct_out_if.source                         out_word
);
  import lsct_pkg::*;

  localparam int PW   = 2 * COORD_WIDTH + 2;
  localparam int LW   = 2 * COORD_WIDTH + 1;
  localparam int SQW  = 4 * COORD_WIDTH + 2;
  localparam int LIMW = LW + LSCT_HD_SQ_WIDTH;
  localparam int CMPW = (SQW > LIMW) ? SQW : LIMW;

  // The squared distance is kept rather than the distance itself; it is
  // all the datapath needs.
  logic [LSCT_HD_SQ_WIDTH-1:0] hd_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_sq_r <= LSCT_HD_SQ_WIDTH'(LSCT_HD_SQ_RESET);
    end else if (cfg_wr_en) begin
      hd_sq_r <= LSCT_HD_SQ_WIDTH'(cfg_wr_data) * LSCT_HD_SQ_WIDTH'(cfg_wr_data);
    end
  end

  // Stages 1 to 3: differences, products, cross products and length.
  logic                   x_valid, x_ready;
  logic signed [PW-1:0]   x_cross_s, x_cross_e;
  logic [LW-1:0]          x_len_sq;
  logic                   x_deg;

  lsct_cross #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_word.valid),
    .in_ready    (in_word.ready),
    .line_ax     (in_word.line_ax),
    .line_ay     (in_word.line_ay),
    .line_bx     (in_word.line_bx),
    .line_by     (in_word.line_by),
    .seg_start_x (in_word.seg_start_x),
    .seg_start_y (in_word.seg_start_y),
    .seg_end_x   (in_word.seg_end_x),
    .seg_end_y   (in_word.seg_end_y),
    .out_valid   (x_valid),
    .out_ready   (x_ready),
    .cross_s     (x_cross_s),
    .cross_e     (x_cross_e),
    .len_sq      (x_len_sq),
    .degenerate  (x_deg)
  );

  // Stages 4 to 6: magnitudes, split squares and the distance limit.
  logic            q_valid, q_ready;
  logic [SQW-1:0]  q_sq_s, q_sq_e;
  logic [LIMW-1:0] q_limit;
  logic            q_crossing, q_deg;

  lsct_square #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_square (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (x_valid),
    .in_ready       (x_ready),
    .cross_s        (x_cross_s),
    .cross_e        (x_cross_e),
    .len_sq         (x_len_sq),
    .degenerate     (x_deg),
    .hd_sq          (hd_sq_r),
    .out_valid      (q_valid),
    .out_ready      (q_ready),
    .sq_s           (q_sq_s),
    .sq_e           (q_sq_e),
    .limit          (q_limit),
    .crossing       (q_crossing),
    .degenerate_out (q_deg)
  );

  // Stage 7: compare against the limit and hold the result word.
  logic out_valid_r, hit_r, deg_r;
  logic out_adv;
  logic near_s, near_e;
  logic hit_nxt;

  assign near_s  = CMPW'(q_sq_s) < CMPW'(q_limit);
  assign near_e  = CMPW'(q_sq_e) < CMPW'(q_limit);
  assign hit_nxt = !q_deg && (near_s || near_e || q_crossing);

  assign out_adv = !out_valid_r || out_word.ready;
  assign q_ready = out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      hit_r <= hit_nxt;
      deg_r <= q_deg;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.hit             = hit_r;
  assign out_word.degenerate_line = deg_r;

endmodule

// ===== rtl/lsct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_port_checks: port-level checks for the line / segment cross test
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module lsct_port_checks (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic out_degenerate_line
);

  // A held result word keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
                                $stable(out_degenerate_line))
    else $error("result word changed while stalled");

  // A degenerate line never reports a hit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate_line |-> !out_hit)
    else $error("hit reported for a degenerate line");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // With the output stage empty every stage can advance, so a query is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("query refused while the output stage is empty");

endmodule

bind line_segment_cross_test_unit lsct_port_checks u_lsct_port_checks (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_word.valid),
  .in_ready            (in_word.ready),
  .out_valid           (out_word.valid),
  .out_ready           (out_word.ready),
  .out_hit             (out_word.hit),
  .out_degenerate_line (out_word.degenerate_line)
);

// ===== tb/sv/lsct_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_tb_pkg: query and verdict types for the cross test bench
// Holds the typed query word and the typed result word that the stimulus
// side and the checker side of the bench share.
// ----------------------------------------------------------------------------
package lsct_tb_pkg;

  localparam int CW = lsct_pkg::LSCT_COORD_WIDTH;

  // One query word: line points A and B, segment endpoints S and E.
  typedef struct {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } query_t;

  // One result word.
  typedef struct packed {
    logic hit;
    logic degenerate_line;
  } verdict_t;

endpackage

// ===== tb/sv/lsct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_checker: result predictor and scoreboard for the cross test unit
// Watches both channels and the distance register port, predicts the verdict
// of every accepted query with exact wide arithmetic and compares it with the
// result words in order.
// ----------------------------------------------------------------------------
module lsct_checker
  import lsct_tb_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lsct_pkg::LSCT_HD_WIDTH-1:0] cfg_wr_data,
  lsct_in_if                                 in_ch,
  lsct_out_if                                out_ch,
  output int                                 pending,
  output int                                 fail_count
);

  localparam int HDW = lsct_pkg::LSCT_HD_WIDTH;

  logic [lsct_pkg::LSCT_HD_WIDTH-1:0] hit_dist;
  verdict_t                           expected_verdicts[$];

  // Exact verdict: squared cross products against hit_dist^2 * |B - A|^2.
  function automatic verdict_t predict_cross(input query_t q,
                                             input logic [lsct_pkg::LSCT_HD_WIDTH-1:0] hd);
    longint       dx, dy, cs, ce, len_sq;
    logic [63:0]  cs_mag, ce_mag;
    logic [127:0] reach, cs_sq, ce_sq;
    verdict_t     v;
    dx = longint'(q.bx) - longint'(q.ax);
    dy = longint'(q.by) - longint'(q.ay);
    v.hit = 1'b0;
    v.degenerate_line = 1'b0;
    if (dx == 0 && dy == 0) begin
      v.degenerate_line = 1'b1;
      return v;
    end
    cs = dx * (longint'(q.sy) - longint'(q.ay)) - dy * (longint'(q.sx) - longint'(q.ax));
    ce = dx * (longint'(q.ey) - longint'(q.ay)) - dy * (longint'(q.ex) - longint'(q.ax));
    len_sq = dx * dx + dy * dy;
    cs_mag = (cs < 0) ? 64'(-cs) : 64'(cs);
    ce_mag = (ce < 0) ? 64'(-ce) : 64'(ce);
    cs_sq = {64'd0, cs_mag} * {64'd0, cs_mag};
    ce_sq = {64'd0, ce_mag} * {64'd0, ce_mag};
    reach = 128'(hd) * 128'(hd) * 128'(len_sq);
    v.hit = (cs_sq < reach) || (ce_sq < reach) || (cs > 0 && ce < 0) || (cs < 0 && ce > 0);
    return v;
  endfunction

  initial begin
    pending = 0;
    fail_count = 0;
    hit_dist = HDW'(lsct_pkg::LSCT_HD_RESET);
  end

  always @(posedge clk) begin
    query_t   seen;
    verdict_t want;
    if (!rst_n) begin
      hit_dist = HDW'(lsct_pkg::LSCT_HD_RESET);
      expected_verdicts.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.ax = in_ch.line_ax;
        seen.ay = in_ch.line_ay;
        seen.bx = in_ch.line_bx;
        seen.by = in_ch.line_by;
        seen.sx = in_ch.seg_start_x;
        seen.sy = in_ch.seg_start_y;
        seen.ex = in_ch.seg_end_x;
        seen.ey = in_ch.seg_end_y;
        expected_verdicts.push_back(predict_cross(seen, hit_dist));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word arrived with no query outstanding");
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.hit !== want.hit) begin
            $error("hit mismatch: expected %0b, actual %0b", want.hit, out_ch.hit);
            fail_count++;
          end
          if (out_ch.degenerate_line !== want.degenerate_line) begin
            $error("degenerate_line mismatch: expected %0b, actual %0b",
                   want.degenerate_line, out_ch.degenerate_line);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        hit_dist = cfg_wr_data;
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for line_segment_cross_test_unit
// Drives a directed set of corner queries and several hundred random queries
// through the unit under a range of hit distances, with random idling on both
// channels, and leaves the checking of result words to the checker beside the unit.
// ----------------------------------------------------------------------------
module testbench;
  import lsct_tb_pkg::*;

  localparam int HDW = lsct_pkg::LSCT_HD_WIDTH;
  // Longest legal run of cycles without any word moving is well below this.
  localparam int WATCHDOG_LIMIT   = 2000;
  // Receiver hold-off long enough for all seven pipeline stages to fill.
  localparam int LONG_HOLD_CYCLES = 60;
  // Pipeline depth plus some margin for the drain at the end.
  localparam int DRAIN_CYCLES     = 12;
  localparam int RANDOM_PER_PHASE = 112;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_wr_en;
  logic [lsct_pkg::LSCT_HD_WIDTH-1:0] cfg_wr_data;

  // Shared between the stimulus, receiver, watchdog and checker processes.
  logic idle_on;
  logic long_hold;
  int   pending;
  int   fail_count;
  int   quiet_cycles;

  lsct_in_if #(.COORD_WIDTH(CW)) in_word ();
  lsct_out_if                    out_word ();

  line_segment_cross_test_unit #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_word    (in_word),
    .out_word   (out_word)
  );

  lsct_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_word),
    .out_ch     (out_word),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The watchdog counts cycles in which neither channel moves a word. A hung
  // pipeline or a lost handshake ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Ready drops in random bursts while idling is on. When the
  // stimulus side asks for a long hold-off, ready stays low long enough that
  // the unit fills up and has to push back on its query channel.
  initial begin
    out_word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_word.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_word.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_word.ready <= 1'b1;
      end
    end
  end

  // Offers one query word and returns at the edge that accepts it. Valid
  // is left high afterwards; the next call, or end_burst, decides at the
  // following falling edge whether it stays high.
  task automatic send_query(input query_t q);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_word.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_word.valid       <= 1'b1;
    in_word.line_ax     <= q.ax;
    in_word.line_ay     <= q.ay;
    in_word.line_bx     <= q.bx;
    in_word.line_by     <= q.by;
    in_word.seg_start_x <= q.sx;
    in_word.seg_start_y <= q.sy;
    in_word.seg_end_x   <= q.ex;
    in_word.seg_end_y   <= q.ey;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
  endtask

  // Withdraws valid after the last word of a burst has been accepted.
  task automatic end_burst();
    @(negedge clk);
    in_word.valid <= 1'b0;
  endtask

  task automatic offer_pts(input int ax, input int ay, input int bx, input int by,
                           input int sx, input int sy, input int ex, input int ey);
    query_t q;
    q.ax = CW'(ax);
    q.ay = CW'(ay);
    q.bx = CW'(bx);
    q.by = CW'(by);
    q.sx = CW'(sx);
    q.sy = CW'(sy);
    q.ex = CW'(ex);
    q.ey = CW'(ey);
    send_query(q);
  endtask

  // The distance register may only change while nothing is in flight, so
  // the query channel is drained first. Every query yields exactly one
  // result word, so an empty scoreboard means an empty pipeline.
  task automatic write_hit_distance(input logic [lsct_pkg::LSCT_HD_WIDTH-1:0] hd_value);
    end_burst();
    wait (pending == 0);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hd_value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] near_coord(input int base, input int spread);
    return CW'(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic signed [CW-1:0] edge_coord();
    case ($urandom_range(0, 5))
      0: return CW'(-32768);
      1: return CW'(32767);
      2: return CW'(0);
      3: return CW'(-1);
      4: return CW'(1);
      default: return CW'($urandom);
    endcase
  endfunction

  // Random query. Fully random coordinates almost never land near the line,
  // so most queries are clustered: all eight coordinates sit in a small
  // window around a random base, where both the distance test and the side
  // test are decided by a few units. Some queries put an endpoint exactly on
  // a line point, some collapse the line, some use extreme coordinates.
  function automatic query_t rand_query();
    query_t q;
    int     kind;
    int     base_x;
    int     base_y;
    int     spread;
    kind = $urandom_range(0, 9);
    q.ax = CW'($urandom);
    q.ay = CW'($urandom);
    q.bx = CW'($urandom);
    q.by = CW'($urandom);
    q.sx = CW'($urandom);
    q.sy = CW'($urandom);
    q.ex = CW'($urandom);
    q.ey = CW'($urandom);
    case (kind)
      0: ;
      1: begin
        q.bx = q.ax;
        q.by = q.ay;
      end
      6: begin
        q.ax = edge_coord();
        q.ay = edge_coord();
        q.bx = edge_coord();
        q.by = edge_coord();
        q.sx = edge_coord();
        q.sy = edge_coord();
        q.ex = edge_coord();
        q.ey = edge_coord();
      end
      default: begin
        spread = (kind < 6) ? 40 : 2000;
        base_x = int'($urandom_range(0, 56000)) - 28000;
        base_y = int'($urandom_range(0, 56000)) - 28000;
        q.ax = near_coord(base_x, spread);
        q.ay = near_coord(base_y, spread);
        q.bx = near_coord(base_x, spread);
        q.by = near_coord(base_y, spread);
        q.sx = near_coord(base_x, spread);
        q.sy = near_coord(base_y, spread);
        q.ex = near_coord(base_x, spread);
        q.ey = near_coord(base_y, spread);
        if (kind == 5) begin
          // An endpoint exactly on the line.
          if ($urandom_range(0, 1) == 0) begin
            q.sx = q.ax;
            q.sy = q.ay;
          end else begin
            q.ex = q.bx;
            q.ey = q.by;
          end
        end
      end
    endcase
    return q;
  endfunction

  initial begin
    int hd_plan[5];

    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    idle_on             = 1'b1;
    long_hold           = 1'b0;
    quiet_cycles        = 0;
    in_word.valid       = 1'b0;
    in_word.line_ax     = '0;
    in_word.line_ay     = '0;
    in_word.line_bx     = '0;
    in_word.line_by     = '0;
    in_word.seg_start_x = '0;
    in_word.seg_start_y = '0;
    in_word.seg_end_x   = '0;
    in_word.seg_end_y   = '0;

    hd_plan[0] = 0;
    hd_plan[1] = 4095;
    hd_plan[2] = 1;
    hd_plan[3] = $urandom_range(2, 4094);
    hd_plan[4] = 37;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed queries with the distance register at its reset value of 4.
    // Collapsed lines, including one at the corner of the coordinate range.
    offer_pts(0, 0, 0, 0, -5, 0, 5, 0);
    offer_pts(-32768, 32767, -32768, 32767, 1, 2, 3, 4);
    // Full-range diagonals: a crossing and a far same-side pair, which push
    // the cross products and their squares to their largest sizes.
    offer_pts(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
    offer_pts(-32768, 32767, 32767, -32768, -32768, -32768, -32767, -32768);
    // Horizontal line through the origin: the distance of a point is its y.
    // Distance exactly 4 is not near, since the comparison is strict.
    offer_pts(0, 0, 10, 0, 0, 4, 5, 4);
    offer_pts(0, 0, 10, 0, 0, 3, 5, 9);
    offer_pts(0, 0, 10, 0, 0, -4, 7, -5);
    offer_pts(0, 0, 10, 0, 0, -3, 7, -50);
    // One endpoint on the line (a hit only through the distance test), then a crossing.
    offer_pts(0, 0, 10, 0, 3, 0, 3, 100);
    offer_pts(0, 0, 10, 0, 3, -20, 8, 20);
    // Both endpoints on the line, then a segment of zero length.
    offer_pts(0, 0, 10, 0, -2, 0, 40, 0);
    offer_pts(0, 0, 10, 0, 5, 5, 5, 5);
    // Vertical and horizontal lines, and diagonals, one of them reversed.
    offer_pts(100, -7, 100, 32767, 90, 0, 110, 0);
    offer_pts(100, -7, 100, 32767, 32767, -32768, 32767, 32767);
    offer_pts(32767, 32767, -32768, -32768, 0, 1, 1, 0);
    offer_pts(-32768, 0, 32767, 0, -32768, -32768, 32767, 32767);
    offer_pts(0, 0, 1, 0, 0, -32768, 0, 32767);
    offer_pts(-32768, -32768, -32768, -32767, 32767, 5, 32767, -5);
    offer_pts(0, 0, 10, 10, 5, 5, 50, 0);

    for (int p = 0; p < 5; p++) begin
      write_hit_distance(HDW'(hd_plan[p]));
      if (p == 0) begin
        // With zero distance the near test is off: an endpoint on the line
        // no longer counts, a true crossing still does.
        offer_pts(0, 0, 10, 0, 3, 0, 3, 100);
        offer_pts(0, 0, 10, 0, -2, 0, 40, 0);
        offer_pts(0, 0, 10, 0, 0, 3, 5, 9);
        offer_pts(0, 0, 10, 0, 3, -20, 8, 20);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 1 && i == 30) begin
          // The receiver holds off while queries keep coming.
          long_hold = 1'b1;
        end
        if (p == 2 && i == 55) begin
          // The sender pauses until every outstanding result is back.
          end_burst();
          wait (pending == 0);
        end
        send_query(rand_query());
      end
    end

    // Last phase: back to the reset distance and no idling on either side.
    write_hit_distance(HDW'(lsct_pkg::LSCT_HD_RESET));
    idle_on = 1'b0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_query(rand_query());
    end
    end_burst();

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lsct_pkg.sv
rtl/lsct_if.sv
rtl/lsct_cross.sv
rtl/lsct_square.sv
rtl/line_segment_cross_test_unit.sv
rtl/lsct_checker.sv
tb/sv/lsct_tb_pkg.sv
tb/sv/lsct_checker.sv
tb/sv/testbench.sv
